// ===== sv/source_tokenizer_unit_defines.svh =====
// Assertion helpers for the tokenizer RTL.
`ifndef SOURCE_TOKENIZER_UNIT_DEFINES_SVH
`define SOURCE_TOKENIZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define STOK_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer check failed");

// Next-cycle implication, disabled during reset
`define STOK_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tokenizer check failed");

`endif

// ===== sv/stok_pkg.sv =====
`timescale 1ns / 1ps

package stok_pkg;

    localparam int OFFSET_BITS_DEFAULT = 16;
    localparam int FIFO_DEPTH          = 4;   // power of two
    localparam logic [15:0] FIELD_MAX  = 16'hFFFF;

    // Character codes
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_LPAREN     = 8'h28;
    localparam logic [7:0] CH_RPAREN     = 8'h29;
    localparam logic [7:0] CH_STAR       = 8'h2A;
    localparam logic [7:0] CH_SLASH      = 8'h2F;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LBRACE     = 8'h7B;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef enum logic [2:0] {
        MODE_IDLE       = 3'd0,
        MODE_SLASH      = 3'd1,
        MODE_IDENT      = 3'd2,
        MODE_STRING     = 3'd3,
        MODE_LINE       = 3'd4,
        MODE_BLOCK      = 3'd5,
        MODE_BLOCK_STAR = 3'd6
    } mode_t;

    typedef enum logic [2:0] {
        KIND_IDENT   = 3'd0,
        KIND_STRING  = 3'd1,
        KIND_LBRACE  = 3'd2,
        KIND_RBRACE  = 3'd3,
        KIND_LPAREN  = 3'd4,
        KIND_RPAREN  = 3'd5,
        KIND_END     = 3'd6,
        KIND_UNKNOWN = 3'd7
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } tok_t;

    // Up to two tokens produced by one byte, in order
    typedef struct packed {
        logic [1:0] count;
        tok_t       tok0;
        tok_t       tok1;
    } push_t;

    typedef struct packed {
        push_t push;
        mode_t mode;
    } scan_t;

endpackage

// ===== sv/stok_if.sv =====
`timescale 1ns / 1ps

// Byte input channel
interface stok_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;

    modport source (output valid, output ch, input ready);
    modport sink   (input valid, input ch, output ready);
endinterface

// Token output channel
interface stok_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last;

    modport source (output valid, output token_kind, output token_start,
                    output token_length, output last, input ready);
    modport sink   (input valid, input token_kind, input token_start,
                    input token_length, input last, output ready);
endinterface

// ===== sv/stok_scan.sv =====
`timescale 1ns / 1ps

// Per-byte scanner: next mode, offsets and the tokens one byte emits.
module stok_scan #(
    parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic [7:0]             ch,
    input  stok_pkg::mode_t        mode,
    input  logic [OFFSET_BITS-1:0] pos,
    input  logic [OFFSET_BITS-1:0] tbegin,
    output stok_pkg::scan_t        res,
    output logic [OFFSET_BITS-1:0] pos_next,
    output logic [OFFSET_BITS-1:0] begin_next
);

    // Saturate an offset into a 16-bit field
    function automatic logic [15:0] clip(input logic [OFFSET_BITS-1:0] v);
        logic [32:0] w;
        w = 33'(v);
        return (w > 33'h0FFFF) ? stok_pkg::FIELD_MAX : w[15:0];
    endfunction

    function automatic stok_pkg::tok_t mk(input stok_pkg::kind_t k,
                                          input logic [15:0] s,
                                          input logic [15:0] l);
        stok_pkg::tok_t t;
        t.kind   = k;
        t.start  = s;
        t.length = l;
        t.last   = 1'b0;
        return t;
    endfunction

    logic                   is_letter;
    logic                   is_tail;
    logic                   is_eol;
    logic [OFFSET_BITS-1:0] span;
    logic [OFFSET_BITS-1:0] pos_inc;

    assign is_letter = ch inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    assign is_tail   = is_letter || (ch inside {[8'h30:8'h39], stok_pkg::CH_UNDERSCORE});
    assign is_eol    = ch inside {stok_pkg::CH_CR, stok_pkg::CH_LF};
    assign span      = (pos >= tbegin) ? (pos - tbegin) : '0;
    assign pos_inc   = (pos == '1) ? pos : (pos + 1'b1);

    // Byte scanned from the idle mode
    logic                   idle_emit;
    stok_pkg::tok_t         idle_tok;
    stok_pkg::mode_t        idle_mode;
    logic                   idle_set;
    logic [OFFSET_BITS-1:0] idle_begin;

    always_comb
    begin
        idle_emit  = 1'b0;
        idle_tok   = mk(stok_pkg::KIND_UNKNOWN, clip(pos), 16'd1);
        idle_mode  = stok_pkg::MODE_IDLE;
        idle_set   = 1'b0;
        idle_begin = pos;
        case (ch)
            stok_pkg::CH_SPACE, stok_pkg::CH_CR, stok_pkg::CH_LF:
            begin
            end
            stok_pkg::CH_SLASH:
            begin
                idle_mode = stok_pkg::MODE_SLASH;
                idle_set  = 1'b1;
            end
            stok_pkg::CH_QUOTE:
            begin
                idle_mode  = stok_pkg::MODE_STRING;
                idle_set   = 1'b1;
                idle_begin = pos_inc;
            end
            stok_pkg::CH_LBRACE:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(stok_pkg::KIND_LBRACE, clip(pos), 16'd1);
            end
            stok_pkg::CH_RBRACE:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(stok_pkg::KIND_RBRACE, clip(pos), 16'd1);
            end
            stok_pkg::CH_LPAREN:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(stok_pkg::KIND_LPAREN, clip(pos), 16'd1);
            end
            stok_pkg::CH_RPAREN:
            begin
                idle_emit = 1'b1;
                idle_tok  = mk(stok_pkg::KIND_RPAREN, clip(pos), 16'd1);
            end
            default:
            begin
                if (is_letter)
                begin
                    idle_mode = stok_pkg::MODE_IDENT;
                    idle_set  = 1'b1;
                end
                else
                begin
                    idle_emit = 1'b1;
                end
            end
        endcase
    end

    // Mode transition; pre is a token closed by this byte, post is a new one
    logic           pre_v;
    logic           post_v;
    logic           take_idle;
    stok_pkg::tok_t pre_tok;
    stok_pkg::tok_t post_tok;

    always_comb
    begin
        pre_v      = 1'b0;
        post_v     = 1'b0;
        take_idle  = 1'b0;
        pre_tok    = mk(stok_pkg::KIND_UNKNOWN, clip(tbegin), 16'd1);
        post_tok   = idle_tok;
        res.mode   = mode;
        begin_next = tbegin;
        pos_next   = pos_inc;

        if (ch == stok_pkg::CH_NUL)
        begin
            // End of text: flush open token, emit end, clear state
            case (mode)
                stok_pkg::MODE_IDENT:
                begin
                    pre_v   = 1'b1;
                    pre_tok = mk(stok_pkg::KIND_IDENT, clip(tbegin), clip(span));
                end
                stok_pkg::MODE_STRING:
                begin
                    pre_v   = 1'b1;
                    pre_tok = mk(stok_pkg::KIND_STRING, clip(tbegin), clip(span));
                end
                stok_pkg::MODE_SLASH:
                begin
                    pre_v = 1'b1;
                end
                default:
                begin
                end
            endcase
            post_v     = 1'b1;
            post_tok   = mk(stok_pkg::KIND_END, clip(pos), 16'd1);
            res.mode   = stok_pkg::MODE_IDLE;
            begin_next = '0;
            pos_next   = '0;
        end
        else
        begin
            case (mode)
                stok_pkg::MODE_SLASH:
                begin
                    if (ch == stok_pkg::CH_SLASH)
                        res.mode = stok_pkg::MODE_LINE;
                    else if (ch == stok_pkg::CH_STAR)
                        res.mode = stok_pkg::MODE_BLOCK_STAR;
                    else
                    begin
                        // lone slash, then rescan this byte
                        pre_v     = 1'b1;
                        take_idle = 1'b1;
                    end
                end
                stok_pkg::MODE_IDENT:
                begin
                    if (!is_tail)
                    begin
                        pre_v     = 1'b1;
                        pre_tok   = mk(stok_pkg::KIND_IDENT, clip(tbegin), clip(span));
                        take_idle = 1'b1;
                    end
                end
                stok_pkg::MODE_STRING:
                begin
                    if (ch == stok_pkg::CH_QUOTE)
                    begin
                        pre_v    = 1'b1;
                        pre_tok  = mk(stok_pkg::KIND_STRING, clip(tbegin), clip(span));
                        res.mode = stok_pkg::MODE_IDLE;
                    end
                end
                stok_pkg::MODE_LINE:
                begin
                    if (is_eol)
                        res.mode = stok_pkg::MODE_IDLE;
                end
                stok_pkg::MODE_BLOCK:
                begin
                    if (ch == stok_pkg::CH_STAR)
                        res.mode = stok_pkg::MODE_BLOCK_STAR;
                end
                stok_pkg::MODE_BLOCK_STAR:
                begin
                    if (ch == stok_pkg::CH_SLASH)
                        res.mode = stok_pkg::MODE_IDLE;
                    else if (ch != stok_pkg::CH_STAR)
                        res.mode = stok_pkg::MODE_BLOCK;
                end
                default:
                begin
                    take_idle = 1'b1;
                end
            endcase

            if (take_idle)
            begin
                post_v   = idle_emit;
                post_tok = idle_tok;
                res.mode = idle_mode;
                if (idle_set)
                    begin_next = idle_begin;
            end
        end

        // Pack in order and flag the final token
        if (pre_v)
        begin
            res.push.tok0      = pre_tok;
            res.push.tok1      = post_tok;
            res.push.count     = post_v ? 2'd2 : 2'd1;
            res.push.tok0.last = !post_v;
            res.push.tok1.last = post_v;
        end
        else
        begin
            res.push.tok0      = post_tok;
            res.push.tok1      = post_tok;
            res.push.count     = post_v ? 2'd1 : 2'd0;
            res.push.tok0.last = 1'b1;
            res.push.tok1.last = 1'b0;
        end
    end

endmodule

// ===== sv/stok_fifo.sv =====
`timescale 1ns / 1ps

// Token queue: takes up to two tokens per cycle, delivers one per transfer.
module stok_fifo (
    input  logic              clk,
    input  logic              rst_n,
    input  stok_pkg::push_t   push,
    output logic              room,
    stok_out_if.source        token_out
);

    localparam int DEPTH = stok_pkg::FIFO_DEPTH;
    localparam int PW    = $clog2(DEPTH);

    stok_pkg::tok_t mem [DEPTH];

    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [PW:0]   count_reg;
    logic [PW:0]   count_next;
    logic          pop;

    assign pop  = token_out.valid && token_out.ready;
    assign room = count_reg <= (PW + 1)'(DEPTH - 2);

    // Pointer and fill update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PW'(push.count);
        rd_ptr_next = pop ? (rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (PW + 1)'(push.count) - (PW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage writes
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
            mem[wr_ptr_reg] <= push.tok0;
        if (push.count == 2'd2)
            mem[PW'(wr_ptr_reg + 1'b1)] <= push.tok1;
    end

    // Head of queue drives the channel
    assign token_out.valid        = count_reg != '0;
    assign token_out.token_kind   = mem[rd_ptr_reg].kind;
    assign token_out.token_start  = mem[rd_ptr_reg].start;
    assign token_out.token_length = mem[rd_ptr_reg].length;
    assign token_out.last         = mem[rd_ptr_reg].last;

endmodule

// ===== sv/source_tokenizer_unit.sv =====
`timescale 1ns / 1ps
// Streaming source-text tokenizer.
// byte_in  : one source byte per transfer on ch; byte 0 marks end of text.
// token_out: tokens with kind, start offset, length and last; last marks
//            the final token caused by a byte. A byte causes 0, 1 or 2 tokens.
// Tokens enter the queue on the transfer of their byte and are offered from its head.
// Throughput: one byte per cycle while byte_in.ready is high. The scanner updates
// its mode once per byte; tokens wait in a 4-entry queue that drains one per cycle
// while token_out.ready is high, and byte_in.ready is high while the queue has room
// for two more tokens, so bytes that cause two tokens take two output transfers.
// Stall: when token_out.ready stays low the queue fills and byte_in.ready
// drops; no token is lost or repeated.
// Reset: mode idle, byte offset and token start zero, queue empty. End of
// text also returns the scanner to this state after emitting the end token.
// Offsets saturate at 2^OFFSET_BITS - 1; output fields saturate at 65535.
`include "source_tokenizer_unit_defines.svh"

module source_tokenizer_unit #(
    parameter int OFFSET_BITS = stok_pkg::OFFSET_BITS_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    stok_in_if.sink    byte_in,
    stok_out_if.source token_out
);

    stok_pkg::mode_t        mode_reg;
    stok_pkg::mode_t        mode_next;
    logic [OFFSET_BITS-1:0] byte_offset_reg;
    logic [OFFSET_BITS-1:0] byte_offset_next;
    logic [OFFSET_BITS-1:0] token_begin_reg;
    logic [OFFSET_BITS-1:0] token_begin_next;

    stok_pkg::scan_t scan_res;
    stok_pkg::push_t fifo_push;
    logic            room;
    logic            accept;

    assign byte_in.ready = room;
    assign accept        = byte_in.valid && byte_in.ready;

    // Scanner for the byte on the input
    stok_scan #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_scan (
        .ch         (byte_in.ch),
        .mode       (mode_reg),
        .pos        (byte_offset_reg),
        .tbegin     (token_begin_reg),
        .res        (scan_res),
        .pos_next   (byte_offset_next),
        .begin_next (token_begin_next)
    );

    // Push tokens only on a transfer
    always_comb
    begin
        fifo_push       = scan_res.push;
        fifo_push.count = accept ? scan_res.push.count : 2'd0;
        mode_next       = accept ? scan_res.mode : mode_reg;
    end

    // Scanner state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= stok_pkg::MODE_IDLE;
            byte_offset_reg <= '0;
            token_begin_reg <= '0;
        end
        else
        begin
            mode_reg <= mode_next;
            if (accept)
            begin
                byte_offset_reg <= byte_offset_next;
                token_begin_reg <= token_begin_next;
            end
        end
    end

    stok_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (fifo_push),
        .room      (room),
        .token_out (token_out)
    );

    // End of text clears the scanner
    `STOK_ASSERT_NEXT(a_eot_clears, accept && byte_in.ch == stok_pkg::CH_NUL, mode_reg == stok_pkg::MODE_IDLE && byte_offset_reg == '0 && token_begin_reg == '0)
    // End of text always leaves a token to deliver
    `STOK_ASSERT_NEXT(a_eot_emits, accept && byte_in.ch == stok_pkg::CH_NUL, token_out.valid)
    // Offset advances by one per nonzero byte until it saturates
    `STOK_ASSERT_NEXT(a_offset_step, accept && byte_in.ch != stok_pkg::CH_NUL && byte_offset_reg != '1, byte_offset_reg == $past(byte_offset_reg) + 1'b1)
    // Offset only moves on a transfer
    `STOK_ASSERT_NEXT(a_offset_hold, !accept, $stable(byte_offset_reg))

endmodule

// ===== test/source_tokenizer_unit_tb.sv =====
`timescale 1ns / 1ps

module source_tokenizer_unit_tb;

    // Predicts the token stream from accepted bytes and checks each token
    class token_scoreboard;
        stok_pkg::mode_t mode;
        logic [15:0]     offset;
        logic [15:0]     tok_begin;
        stok_pkg::tok_t  pending[$];
        int              mismatches;
        int              tokens_checked;
        int              texts_ended;

        function new();
            clear_scan();
            mismatches     = 0;
            tokens_checked = 0;
            texts_ended    = 0;
        endfunction

        function void clear_scan();
            mode      = stok_pkg::MODE_IDLE;
            offset    = '0;
            tok_begin = '0;
        endfunction

        function logic [15:0] sat_inc(logic [15:0] v);
            return (v == 16'hFFFF) ? v : v + 16'd1;
        endfunction

        function logic [15:0] span(logic [15:0] pos);
            return (pos >= tok_begin) ? pos - tok_begin : 16'd0;
        endfunction

        function bit is_letter(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_ident_tail(logic [7:0] c);
            return is_letter(c) || (c >= "0" && c <= "9") || c == stok_pkg::CH_UNDERSCORE;
        endfunction

        function void add_token(stok_pkg::kind_t kind, logic [15:0] start,
                                logic [15:0] length);
            stok_pkg::tok_t t;
            t.kind   = kind;
            t.start  = start;
            t.length = length;
            t.last   = 1'b0;
            pending.push_back(t);
        endfunction

        // Byte seen between tokens
        function void scan_from_idle(logic [7:0] c, logic [15:0] pos);
            mode = stok_pkg::MODE_IDLE;
            case (c)
                stok_pkg::CH_SPACE, stok_pkg::CH_CR, stok_pkg::CH_LF:
                begin
                end
                stok_pkg::CH_SLASH:
                begin
                    mode      = stok_pkg::MODE_SLASH;
                    tok_begin = pos;
                end
                stok_pkg::CH_QUOTE:
                begin
                    mode      = stok_pkg::MODE_STRING;
                    tok_begin = sat_inc(pos);
                end
                stok_pkg::CH_LBRACE: add_token(stok_pkg::KIND_LBRACE, pos, 16'd1);
                stok_pkg::CH_RBRACE: add_token(stok_pkg::KIND_RBRACE, pos, 16'd1);
                stok_pkg::CH_LPAREN: add_token(stok_pkg::KIND_LPAREN, pos, 16'd1);
                stok_pkg::CH_RPAREN: add_token(stok_pkg::KIND_RPAREN, pos, 16'd1);
                default:
                begin
                    if (is_letter(c))
                    begin
                        mode      = stok_pkg::MODE_IDENT;
                        tok_begin = pos;
                    end
                    else
                    begin
                        add_token(stok_pkg::KIND_UNKNOWN, pos, 16'd1);
                    end
                end
            endcase
        endfunction

        function void note_byte(logic [7:0] c);
            logic [15:0] pos;
            int          n_before;
            pos      = offset;
            n_before = pending.size();

            // End of text: flush the open token, then the end marker
            if (c == stok_pkg::CH_NUL)
            begin
                if (mode == stok_pkg::MODE_IDENT)
                    add_token(stok_pkg::KIND_IDENT, tok_begin, span(pos));
                else if (mode == stok_pkg::MODE_STRING)
                    add_token(stok_pkg::KIND_STRING, tok_begin, span(pos));
                else if (mode == stok_pkg::MODE_SLASH)
                    add_token(stok_pkg::KIND_UNKNOWN, tok_begin, 16'd1);
                add_token(stok_pkg::KIND_END, pos, 16'd1);
                pending[pending.size() - 1].last = 1'b1;
                texts_ended++;
                clear_scan();
                return;
            end

            case (mode)
                stok_pkg::MODE_SLASH:
                begin
                    if (c == stok_pkg::CH_SLASH)
                        mode = stok_pkg::MODE_LINE;
                    else if (c == stok_pkg::CH_STAR)
                        mode = stok_pkg::MODE_BLOCK_STAR;
                    else
                    begin
                        add_token(stok_pkg::KIND_UNKNOWN, tok_begin, 16'd1);
                        scan_from_idle(c, pos);
                    end
                end
                stok_pkg::MODE_IDENT:
                begin
                    if (!is_ident_tail(c))
                    begin
                        add_token(stok_pkg::KIND_IDENT, tok_begin, span(pos));
                        scan_from_idle(c, pos);
                    end
                end
                stok_pkg::MODE_STRING:
                begin
                    if (c == stok_pkg::CH_QUOTE)
                    begin
                        add_token(stok_pkg::KIND_STRING, tok_begin, span(pos));
                        mode = stok_pkg::MODE_IDLE;
                    end
                end
                stok_pkg::MODE_LINE:
                begin
                    if (c == stok_pkg::CH_CR || c == stok_pkg::CH_LF)
                        mode = stok_pkg::MODE_IDLE;
                end
                stok_pkg::MODE_BLOCK:
                begin
                    if (c == stok_pkg::CH_STAR)
                        mode = stok_pkg::MODE_BLOCK_STAR;
                end
                stok_pkg::MODE_BLOCK_STAR:
                begin
                    if (c == stok_pkg::CH_SLASH)
                        mode = stok_pkg::MODE_IDLE;
                    else if (c != stok_pkg::CH_STAR)
                        mode = stok_pkg::MODE_BLOCK;
                end
                default: scan_from_idle(c, pos);
            endcase

            offset = sat_inc(offset);
            if (pending.size() > n_before)
                pending[pending.size() - 1].last = 1'b1;
        endfunction

        function void check_token(stok_pkg::tok_t got);
            stok_pkg::tok_t want;
            tokens_checked++;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected token: kind %0d start %0d length %0d last %0b",
                             got.kind, got.start, got.length, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.kind !== want.kind || got.start !== want.start ||
                got.length !== want.length || got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("token mismatch: expected kind %0d start %0d length %0d last %0b",
                             want.kind, want.start, want.length, want.last);
                    $display("                got      kind %0d start %0d length %0d last %0b",
                             got.kind, got.start, got.length, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   quiet;
    int   bytes_sent;

    stok_in_if  byte_in ();
    stok_out_if token_out ();

    token_scoreboard sb;

    source_tokenizer_unit i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_in),
        .token_out(token_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Watchdog
    initial
    begin
        #(4_000_000);
        $display("FAILURE");
        $finish;
    end

    // Mostly short gaps, now and then a long one; none in quiet stretches
    function int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Observe both channels at the clock edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (byte_in.valid && byte_in.ready)
                sb.note_byte(byte_in.ch);
            if (token_out.valid && token_out.ready)
                sb.check_token('{kind: stok_pkg::kind_t'(token_out.token_kind),
                                 start: token_out.token_start,
                                 length: token_out.token_length,
                                 last: token_out.last});
        end
    end

    task send_byte(input logic [7:0] c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_in.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_in.valid <= 1'b1;
        byte_in.ch    <= c;
        @(posedge clk);
        while (!byte_in.ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    task run_token_sink();
        int gap;
        forever
        begin
            gap = pick_gap();
            if (gap > 0)
            begin
                token_out.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            token_out.ready <= 1'b1;
            @(posedge clk);
            while (!token_out.valid)
                @(posedge clk);
        end
    endtask

    function logic [7:0] pick_letter();
        if ($urandom_range(0, 1))
            return 8'($urandom_range("a", "z"));
        return 8'($urandom_range("A", "Z"));
    endfunction

    function logic [7:0] pick_tail();
        int r;
        r = $urandom_range(0, 9);
        if (r < 6)
            return pick_letter();
        else if (r < 9)
            return 8'($urandom_range("0", "9"));
        return stok_pkg::CH_UNDERSCORE;
    endfunction

    // Any nonzero byte other than the two given
    function logic [7:0] pick_other(logic [7:0] a, logic [7:0] b);
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == a || c == b);
        return c;
    endfunction

    // One random lexical fragment, mostly well formed
    task send_fragment();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 8)
            send_byte(stok_pkg::CH_NUL);
        else if (r < 30)
        begin
            send_byte(pick_letter());
            n = $urandom_range(0, 8);
            repeat (n) send_byte(pick_tail());
        end
        else if (r < 42)
        begin
            send_byte(stok_pkg::CH_QUOTE);
            n = $urandom_range(0, 8);
            repeat (n) send_byte(pick_other(stok_pkg::CH_QUOTE, stok_pkg::CH_QUOTE));
            if ($urandom_range(0, 99) < 85)
                send_byte(stok_pkg::CH_QUOTE);
        end
        else if (r < 50)
        begin
            send_byte(stok_pkg::CH_SLASH);
            send_byte(stok_pkg::CH_SLASH);
            n = $urandom_range(0, 6);
            repeat (n) send_byte(pick_other(stok_pkg::CH_CR, stok_pkg::CH_LF));
            if ($urandom_range(0, 99) < 90)
                send_byte($urandom_range(0, 1) ? stok_pkg::CH_CR : stok_pkg::CH_LF);
        end
        else if (r < 60)
        begin
            send_byte(stok_pkg::CH_SLASH);
            send_byte(stok_pkg::CH_STAR);
            n = $urandom_range(0, 6);
            repeat (n) send_byte($urandom_range(0, 2) == 0 ? stok_pkg::CH_STAR :
                                 pick_other(stok_pkg::CH_STAR, stok_pkg::CH_STAR));
            if ($urandom_range(0, 99) < 85)
            begin
                if ($urandom_range(0, 1))
                    send_byte(stok_pkg::CH_STAR);
                send_byte(stok_pkg::CH_SLASH);
            end
        end
        else if (r < 72)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
            begin
                case ($urandom_range(0, 2))
                    0: send_byte(stok_pkg::CH_SPACE);
                    1: send_byte(stok_pkg::CH_CR);
                    default: send_byte(stok_pkg::CH_LF);
                endcase
            end
        end
        else if (r < 84)
        begin
            case ($urandom_range(0, 3))
                0: send_byte(stok_pkg::CH_LBRACE);
                1: send_byte(stok_pkg::CH_RBRACE);
                2: send_byte(stok_pkg::CH_LPAREN);
                default: send_byte(stok_pkg::CH_RPAREN);
            endcase
        end
        else if (r < 88)
            send_byte(stok_pkg::CH_SLASH);
        else if (r < 94)
            send_byte($urandom_range(0, 3) == 0 ? 8'h09 : 8'($urandom_range("0", "9")));
        else
            send_byte(8'($urandom_range(1, 255)));
    endtask

    initial
    begin
        int drain;
        sb              = new();
        quiet           = 1'b0;
        bytes_sent      = 0;
        rst_n           = 1'b0;
        byte_in.valid   = 1'b0;
        byte_in.ch      = 8'h00;
        token_out.ready = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        fork
            run_token_sink();
        join_none

        // Directed: extremes, every token kind, comments and delimiters
        send_text("Az_9{})(");
        send_byte(stok_pkg::CH_SPACE);
        send_byte(stok_pkg::CH_CR);
        send_byte(stok_pkg::CH_LF);
        send_byte(8'h09);
        send_byte(8'hFF);
        send_text("/x/*/");
        send_text("//c");
        send_byte(stok_pkg::CH_LF);
        send_text("\"q");
        send_byte(stok_pkg::CH_NUL);

        // Long unterminated string, flushed at end of text
        quiet = 1'b1;
        send_byte(stok_pkg::CH_QUOTE);
        repeat (200) send_byte("a");
        send_byte(stok_pkg::CH_NUL);
        quiet = 1'b0;

        // Random text
        while (bytes_sent < 1200)
            send_fragment();
        send_byte(stok_pkg::CH_NUL);
        byte_in.valid <= 1'b0;

        drain = 0;
        while (sb.pending.size() != 0 && drain < 5000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (sb.pending.size() != 0)
        begin
            $display("%0d expected tokens never arrived", sb.pending.size());
            sb.mismatches++;
        end

        $display("sent %0d bytes in %0d texts, checked %0d tokens, %0d mismatches",
                 bytes_sent, sb.texts_ended, sb.tokens_checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
